// File: hdl/whmd_pkg.sv
// Shared types and constants for the waypoint heading motor drive.
// Holds the CORDIC angle table, the pipeline word layout and register indexes.
// No dependencies.
`default_nettype none

package whmd_pkg;

  localparam int CORDIC_STEPS = 18;

  // atan(2^-i) in degrees, Q16, rounded to nearest
  localparam logic [21:0] ATAN_Q16 [CORDIC_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29
  };

  // Angles in Q16 degrees
  localparam logic [21:0] OCT_MAX = 22'd2949120;   // 45 deg
  localparam logic [23:0] Q_45    = 24'd2949120;
  localparam logic [23:0] Q_90    = 24'd5898240;
  localparam logic [23:0] Q_135   = 24'd8847360;
  localparam logic [23:0] Q_180   = 24'd11796480;

  // speed * 624 / 255 : reciprocal estimate a little below 624 * 2^22 / 255,
  // so the quotient estimate is never high and at most one low
  localparam logic [31:0] SPEED_RECIP = 32'd10263552;
  localparam logic [9:0]  SPEED_GAIN  = 10'd624;
  localparam logic [17:0] SPEED_DIV   = 18'd255;
  localparam logic [10:0] SPIN_BASE   = 11'd400;
  localparam logic [10:0] DRIVE_DUTY  = 11'd800;

  localparam logic [9:0] BEARING_OFFSET = 10'd450;
  localparam logic [9:0] FULL_TURN      = 10'd360;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTORS   = 2'd1;
  localparam logic [8:0] DEADBAND_RESET = 9'd10;

  // How the first-quadrant angle is formed
  typedef enum logic [2:0] {
    MODE_ZERO,    // on the x axis
    MODE_RIGHT,   // on the y axis
    MODE_DIAG,    // |dx| == |dy|
    MODE_OCT,     // |dy| < |dx|, CORDIC angle used directly
    MODE_COMP     // |dy| > |dx|, 90 minus CORDIC angle
  } mode_t;

  typedef struct packed {
    logic        active;
    logic        found;
    logic        dx_neg;
    logic        dy_neg;
    mode_t       mode;
    logic [8:0]  heading;
    logic [7:0]  speed;
    logic [9:0]  spin_q0;
  } whmd_side_t;

  typedef struct packed {
    logic signed [34:0] x;
    logic signed [34:0] y;
    logic signed [24:0] z;
    whmd_side_t         side;
  } whmd_word_t;

endpackage

`default_nettype wire

// File: hdl/whmd_if.sv
// Channel interfaces for the waypoint heading motor drive.
// whmd_pose_if carries one pose word in, whmd_drive_if one drive word out.
// No dependencies.
`default_nettype none

interface whmd_pose_if;
  logic               valid;
  logic               ready;
  logic               status_normal;
  logic signed [14:0] current_x;
  logic signed [14:0] current_y;
  logic signed [14:0] target_x;
  logic signed [14:0] target_y;
  logic [8:0]         current_heading;
  logic [7:0]         speed_request;

  modport source (
    output valid, status_normal, current_x, current_y, target_x, target_y,
           current_heading, speed_request,
    input  ready
  );
  modport sink (
    input  valid, status_normal, current_x, current_y, target_x, target_y,
           current_heading, speed_request,
    output ready
  );
endinterface

interface whmd_drive_if;
  logic        valid;
  logic        ready;
  logic [10:0] left_forward_duty;
  logic [10:0] left_reverse_duty;
  logic [10:0] right_forward_duty;
  logic [10:0] right_reverse_duty;
  logic        target_found;
  logic [8:0]  bearing_degrees;

  modport source (
    output valid, left_forward_duty, left_reverse_duty, right_forward_duty,
           right_reverse_duty, target_found, bearing_degrees,
    input  ready
  );
  modport sink (
    input  valid, left_forward_duty, left_reverse_duty, right_forward_duty,
           right_reverse_duty, target_found, bearing_degrees,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/waypoint_heading_motor_drive.sv
// Top level of the waypoint heading motor drive: configuration registers and
// the pipeline front stage, CORDIC cell chain and back end. Uses whmd_pkg,
// whmd_if, whmd_front, whmd_cordic_cell and whmd_finish.
`default_nettype none

// Takes one pose word per clock while the output accepts, and returns one drive
// word per pose word, in order, through one front stage, a chain of 18 CORDIC
// cells that each perform one vectoring step of atan2, and three back-end stages
// for bearing, spin duty and steering. Each stage holds its own word and moves it
// as soon as the next stage has room, so the block keeps accepting while a
// finished word waits at the output until every stage holds a word. Write
// angle_deadband (index 0) and motors_enabled (index 1) through the write port
// only while no word is in flight; other indexes are ignored.
module waypoint_heading_motor_drive #(
  parameter int ARRIVAL_WINDOW = 10
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  whmd_pose_if.sink                               pose,
  whmd_drive_if.source                            drive,
  input  wire logic                               write_en,
  input  wire logic [whmd_pkg::CFG_INDEX_W-1:0]   write_index,
  input  wire logic [whmd_pkg::CFG_DATA_W-1:0]    write_data
);

  localparam int NCELL = whmd_pkg::CORDIC_STEPS;

  logic [8:0] angle_deadband;
  logic       motors_enabled;

  logic                 stage_valid [NCELL+1];
  logic                 stage_ready [NCELL+1];
  whmd_pkg::whmd_word_t stage_data  [NCELL+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_deadband <= whmd_pkg::DEADBAND_RESET;
      motors_enabled <= 1'b0;
    end else if (write_en) begin
      case (write_index)
        whmd_pkg::REG_DEADBAND: angle_deadband <= write_data[8:0];
        whmd_pkg::REG_MOTORS:   motors_enabled <= write_data[0];
        default: ;
      endcase
    end
  end

  whmd_front #(
    .ARRIVAL_WINDOW (ARRIVAL_WINDOW)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .pose           (pose),
    .motors_enabled (motors_enabled),
    .out_valid      (stage_valid[0]),
    .out_ready      (stage_ready[0]),
    .out_data       (stage_data[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    whmd_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  whmd_finish u_finish (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (stage_valid[NCELL]),
    .in_ready       (stage_ready[NCELL]),
    .in_data        (stage_data[NCELL]),
    .angle_deadband (angle_deadband),
    .drive          (drive)
  );

endmodule

`default_nettype wire

// File: hdl/whmd_front.sv
// Input stage: offsets to target, arrival test, octant folding, speed estimate.
// Feeds the first CORDIC cell. Uses whmd_pkg and whmd_pose_if.
`default_nettype none

module whmd_front #(
  parameter int ARRIVAL_WINDOW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  whmd_pose_if.sink          pose,
  input  wire logic          motors_enabled,
  output logic               out_valid,
  input  wire logic          out_ready,
  output whmd_pkg::whmd_word_t out_data
);

  logic                 valid;
  whmd_pkg::whmd_word_t data;
  whmd_pkg::whmd_word_t data_next;

  logic signed [15:0] dx, dy;
  logic [14:0]        ax, ay, big, small_leg;
  logic [31:0]        spin_prod;
  whmd_pkg::mode_t    mode;

  assign pose.ready = !valid || out_ready;

  always_comb begin
    dx = {pose.target_x[14], pose.target_x} - {pose.current_x[14], pose.current_x};
    dy = {pose.target_y[14], pose.target_y} - {pose.current_y[14], pose.current_y};
    ax = dx[15] ? 15'(-dx) : dx[14:0];
    ay = dy[15] ? 15'(-dy) : dy[14:0];

    if (ay == 15'd0) begin
      mode = whmd_pkg::MODE_ZERO;
    end else if (ax == 15'd0) begin
      mode = whmd_pkg::MODE_RIGHT;
    end else if (ax == ay) begin
      mode = whmd_pkg::MODE_DIAG;
    end else if (ay < ax) begin
      mode = whmd_pkg::MODE_OCT;
    end else begin
      mode = whmd_pkg::MODE_COMP;
    end

    // Fold to the first octant: the longer leg drives x, except on the y axis
    if (mode == whmd_pkg::MODE_COMP) begin
      big       = ay;
      small_leg = ax;
    end else begin
      big       = ax;
      small_leg = ay;
    end

    spin_prod = 32'(pose.speed_request) * whmd_pkg::SPEED_RECIP;

    data_next.x              = {4'b0, big, 16'b0};
    data_next.y              = {4'b0, small_leg, 16'b0};
    data_next.z              = '0;
    data_next.side.active    = pose.status_normal && motors_enabled;
    data_next.side.found     = ({1'b0, ax} < 16'(ARRIVAL_WINDOW)) &&
                               ({1'b0, ay} < 16'(ARRIVAL_WINDOW));
    data_next.side.dx_neg    = dx[15];
    data_next.side.dy_neg    = dy[15];
    data_next.side.mode      = mode;
    data_next.side.heading   = pose.current_heading;
    data_next.side.speed     = pose.speed_request;
    data_next.side.spin_q0   = spin_prod[31:22];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pose.ready) begin
      valid <= pose.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pose.ready && pose.valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

`default_nettype wire

// File: hdl/whmd_cordic_cell.sv
// One vectoring CORDIC step: rotate toward the x axis and accumulate the angle.
// A chain of these forms the atan pipeline. Uses whmd_pkg.
`default_nettype none

module whmd_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire whmd_pkg::whmd_word_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output whmd_pkg::whmd_word_t      out_data
);

  logic                 valid;
  whmd_pkg::whmd_word_t data;
  whmd_pkg::whmd_word_t data_next;
  logic signed [34:0]   xs, ys;
  logic signed [24:0]   step_angle;

  assign in_ready = !valid || out_ready;

  always_comb begin
    xs         = in_data.x >>> STEP;
    ys         = in_data.y >>> STEP;
    step_angle = $signed({3'b0, whmd_pkg::ATAN_Q16[STEP]});
    data_next  = in_data;
    if (in_data.y > 35'sd0) begin
      data_next.x = in_data.x + ys;
      data_next.y = in_data.y - xs;
      data_next.z = in_data.z + step_angle;
    end else begin
      data_next.x = in_data.x - ys;
      data_next.y = in_data.y + xs;
      data_next.z = in_data.z - step_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

`default_nettype wire

// File: hdl/whmd_finish.sv
// Back end: angle to whole degrees, compass bearing, spin duty, steering decision
// and the output register. Uses whmd_pkg and whmd_drive_if.
`default_nettype none

module whmd_finish (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire whmd_pkg::whmd_word_t in_data,
  input  wire logic [8:0]           angle_deadband,
  whmd_drive_if.source              drive
);

  // Stage A: degrees and corrected speed quotient
  logic                 a_valid;
  logic [7:0]           a_deg;
  logic [9:0]           a_q;
  whmd_pkg::whmd_side_t a_side;
  logic                 a_ready;
  // Stage B: bearing and spin duty
  logic                 b_valid;
  logic [8:0]           b_bearing;
  logic [10:0]          b_spin;
  whmd_pkg::whmd_side_t b_side;
  logic                 b_ready;
  // Stage C: output register
  logic                 c_valid;
  logic                 c_ready;
  logic [10:0]          lf, lr, rf, rr;
  logic                 found;
  logic [8:0]           bearing;

  logic [21:0]          zc;
  logic [23:0]          mag;
  logic [17:0]          spin_p, spin_r;
  logic [9:0]           q_next;
  logic [9:0]           turn;
  logic [9:0]           bearing_wide;
  logic signed [10:0]   err, err_neg;
  logic                 spin_right, spin_left;
  logic [10:0]          lf_next, lr_next, rf_next, rr_next;
  logic                 found_next;
  logic [8:0]           bearing_next;

  assign c_ready  = !c_valid || drive.ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // Stage A logic
  always_comb begin
    if (in_data.z < 25'sd0) begin
      zc = '0;
    end else if (in_data.z > $signed({3'b0, whmd_pkg::OCT_MAX})) begin
      zc = whmd_pkg::OCT_MAX;
    end else begin
      zc = in_data.z[21:0];
    end

    // Quadrant fold and the 180 mirror for negative dx merged into one add
    case (in_data.side.mode)
      whmd_pkg::MODE_ZERO:  mag = in_data.side.dx_neg ? whmd_pkg::Q_180 : 24'd0;
      whmd_pkg::MODE_RIGHT: mag = whmd_pkg::Q_90;
      whmd_pkg::MODE_DIAG:  mag = in_data.side.dx_neg ? whmd_pkg::Q_135 : whmd_pkg::Q_45;
      whmd_pkg::MODE_OCT:   mag = in_data.side.dx_neg ? whmd_pkg::Q_180 - {2'b0, zc}
                                                      : {2'b0, zc};
      whmd_pkg::MODE_COMP:  mag = in_data.side.dx_neg ? whmd_pkg::Q_90 + {2'b0, zc}
                                                      : whmd_pkg::Q_90 - {2'b0, zc};
      default:              mag = '0;
    endcase

    spin_p = 18'(in_data.side.speed) * 18'(whmd_pkg::SPEED_GAIN);
    spin_r = spin_p - ({in_data.side.spin_q0, 8'b0} - 18'(in_data.side.spin_q0));
    q_next = in_data.side.spin_q0 + 10'(spin_r >= whmd_pkg::SPEED_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_deg  <= mag[23:16];
      a_q    <= q_next;
      a_side <= in_data.side;
    end
  end

  // Stage B logic: bearing = (450 - a) mod 360, with a negated when dy is negative
  always_comb begin
    turn         = a_side.dy_neg ? whmd_pkg::BEARING_OFFSET + 10'(a_deg)
                                 : whmd_pkg::BEARING_OFFSET - 10'(a_deg);
    bearing_wide = (turn >= whmd_pkg::FULL_TURN) ? turn - whmd_pkg::FULL_TURN : turn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_bearing <= bearing_wide[8:0];
      b_spin    <= whmd_pkg::SPIN_BASE + 11'(a_q);
      b_side    <= a_side;
    end
  end

  // Stage C logic: heading error, no wrap
  always_comb begin
    err        = $signed({2'b0, b_bearing}) - $signed({2'b0, b_side.heading});
    err_neg    = -err;
    spin_right = err[10] && (err_neg > $signed({2'b0, angle_deadband}));
    spin_left  = !err[10] && (err > $signed({2'b0, angle_deadband}));

    lf_next      = '0;
    lr_next      = '0;
    rf_next      = '0;
    rr_next      = '0;
    found_next   = 1'b0;
    bearing_next = '0;
    if (b_side.active) begin
      if (b_side.found) begin
        found_next = 1'b1;
      end else begin
        bearing_next = b_bearing;
        if (spin_right) begin
          lf_next = b_spin;
          rr_next = b_spin;
        end else if (spin_left) begin
          lr_next = b_spin;
          rf_next = b_spin;
        end else begin
          lf_next = whmd_pkg::DRIVE_DUTY;
          rf_next = whmd_pkg::DRIVE_DUTY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) begin
      lf      <= lf_next;
      lr      <= lr_next;
      rf      <= rf_next;
      rr      <= rr_next;
      found   <= found_next;
      bearing <= bearing_next;
    end
  end

  assign drive.valid              = c_valid;
  assign drive.left_forward_duty  = lf;
  assign drive.left_reverse_duty  = lr;
  assign drive.right_forward_duty = rf;
  assign drive.right_reverse_duty = rr;
  assign drive.target_found       = found;
  assign drive.bearing_degrees    = bearing;

  // Arrival word carries no drive and no bearing
  assert property (@(posedge clk) disable iff (rst)
    c_valid && found |-> lf == 11'd0 && lr == 11'd0 && rf == 11'd0 && rr == 11'd0 &&
                         bearing == 9'd0)
    else $error("arrival word with drive or bearing");

  assert property (@(posedge clk) disable iff (rst)
    c_valid |-> bearing < 9'd360)
    else $error("bearing out of range");

  // Spin left pairs left reverse with right forward at the same duty
  assert property (@(posedge clk) disable iff (rst)
    c_valid && lr != 11'd0 |-> rf == lr && lf == 11'd0 && rr == 11'd0 &&
                               lr >= whmd_pkg::SPIN_BASE && lr <= 11'd1024)
    else $error("spin left duties inconsistent");

  // No left drive means the word is idle or arrival: nothing else set
  assert property (@(posedge clk) disable iff (rst)
    c_valid && lf == 11'd0 && lr == 11'd0 |-> rf == 11'd0 && rr == 11'd0 &&
                                               bearing == 9'd0)
    else $error("right drive without left drive");

endmodule

`default_nettype wire
